FILE: hw/rtl/fpsvf_pkg.sv
package fpsvf_pkg;

  // cell count and index width
  localparam int CELLS  = 8;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  // exp2 polynomial constants and cutoff clamp
  localparam logic [31:0]        POLY_GAIN   = 32'd715827883;
  localparam logic [31:0]        POLY_OFFSET = 32'd715827882;
  localparam logic signed [31:0] FM_LIMIT    = 32'sd5378279;

  // register indexes
  localparam logic [1:0] REG_CENTER  = 2'd0;
  localparam logic [1:0] REG_DAMPING = 2'd1;
  localparam logic [1:0] REG_DEPTH   = 2'd2;
  localparam logic [1:0] REG_FTYPE   = 2'd3;

  // register reset values
  localparam logic [30:0] CENTER_RESET  = 31'd61193109;
  localparam logic [30:0] DAMPING_RESET = 31'd1193046471;
  localparam logic [14:0] DEPTH_RESET   = 15'd8192;

  // filter type codes, anything else picks highpass
  localparam logic [1:0] FT_LOWPASS  = 2'd0;
  localparam logic [1:0] FT_BANDPASS = 2'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_CTRL,
    ST_CALC_CTRL,
    ST_MUL_SQ,
    ST_CALC_SQ,
    ST_MUL_POLY,
    ST_CALC_POLY,
    ST_MUL_FM,
    ST_CALC_FM,
    ST_MUL_LP,
    ST_CALC_LP,
    ST_CALC_HPA,
    ST_CALC_HPB,
    ST_MUL_BP,
    ST_CALC_BP,
    ST_SUM,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [30:0] center;
    logic [30:0] damping;
    logic [14:0] depth;
    logic [1:0]  ftype;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  // arithmetic shift right by 13, then saturate to 16 bits
  function automatic logic [15:0] sat16(input logic [31:0] v);
    logic [15:0] r;
    if (v[31:28] == {4{v[31]}}) begin
      r = v[28:13];
    end else if (v[31]) begin
      r = 16'h8000;
    end else begin
      r = 16'h7FFF;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/fpsvf_mul.sv
module fpsvf_mul import fpsvf_pkg::*; (
  input  logic        clk,
  input  mul_req_t    req,
  output logic [31:0] hi,
  output logic [31:0] lo
);

  logic signed [63:0] prod;

  // registered signed 32x32 product
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

  // rounded high half and plain low half
  assign hi = prod[63:32] + {31'd0, prod[31]};
  assign lo = prod[31:0];

endmodule

FILE: hw/rtl/fpsvf_core.sv
module fpsvf_core import fpsvf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cell_req,
  input  logic [15:0] sample,
  input  logic [15:0] control,
  input  logic        connected,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  cell_out,
  output logic [15:0] selected_out,
  output logic [15:0] lowpass_out,
  output logic [15:0] bandpass_out,
  output logic [15:0] highpass_out,
  output mul_req_t    mul_req,
  input  logic [31:0] mul_hi,
  input  logic [31:0] mul_lo
);

  state_t state, state_next;
  logic   pass;
  logic   live;
  logic   live_in;
  logic   accept;
  logic   fin_load;

  logic [2:0]  cell_r;
  logic [15:0] ctl_r;
  logic [31:0] inp, prev, lp, bp, hp, fm, acc, hpbase;
  logic [31:0] lpt, bpt, hpt;
  logic [4:0]  shv;
  logic [15:0] olp, obp, ohp;

  logic [31:0] lp_mem [CELLS];
  logic [31:0] bp_mem [CELLS];
  logic [31:0] prev_mem [CELLS];

  logic [CELL_W-1:0]  idx_in, idx_r;
  logic [31:0]        mulq, in_sum, poly_sum, bp_sum;
  logic signed [6:0]  shv_raw;
  logic signed [31:0] fm_clamped;

  assign idx_in  = CELL_W'(cell_req);
  assign idx_r   = CELL_W'(cell_r);
  assign live_in = connected && (int'(cell_req) < CELLS);
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_load = (state == ST_FIN) && (!out_valid || out_ready);

  // shared helpers on the multiplier result, plus the sum of inp and prev
  assign mulq       = {mul_hi[29:0], 2'b00};
  assign in_sum     = inp + prev;
  assign shv_raw    = 7'sd6 - {{2{mul_lo[31]}}, mul_lo[31:27]};
  assign poly_sum   = {mul_hi[28:0], 3'b000} + POLY_OFFSET;
  assign fm_clamped = ($signed(mul_hi) > FM_LIMIT) ? FM_LIMIT : $signed(mul_hi);
  assign bp_sum     = bp + mulq;

  // multiplier operand select
  always_comb begin
    mul_req = '0;
    case (state)
      ST_MUL_CTRL: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{16{ctl_r[15]}}, ctl_r};
        mul_req.b  = {17'd0, cfg.depth};
      end
      ST_MUL_SQ: begin
        mul_req.en = 1'b1;
        mul_req.a  = acc;
        mul_req.b  = acc;
      end
      ST_MUL_POLY: begin
        mul_req.en = 1'b1;
        mul_req.a  = acc;
        mul_req.b  = POLY_GAIN;
      end
      ST_MUL_FM: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, cfg.center};
        mul_req.b  = acc;
      end
      ST_MUL_LP: begin
        mul_req.en = 1'b1;
        mul_req.a  = fm;
        mul_req.b  = bp;
      end
      ST_CALC_LP: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, cfg.damping};
        mul_req.b  = bp;
      end
      ST_MUL_BP: begin
        mul_req.en = 1'b1;
        mul_req.a  = fm;
        mul_req.b  = hp;
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = live_in ? ST_MUL_CTRL : ST_FIN;
        end
      end
      ST_MUL_CTRL:  state_next = ST_CALC_CTRL;
      ST_CALC_CTRL: state_next = ST_MUL_SQ;
      ST_MUL_SQ:    state_next = ST_CALC_SQ;
      ST_CALC_SQ:   state_next = ST_MUL_POLY;
      ST_MUL_POLY:  state_next = ST_CALC_POLY;
      ST_CALC_POLY: state_next = ST_MUL_FM;
      ST_MUL_FM:    state_next = ST_CALC_FM;
      ST_CALC_FM:   state_next = ST_MUL_LP;
      ST_MUL_LP:    state_next = ST_CALC_LP;
      ST_CALC_LP:   state_next = ST_CALC_HPA;
      ST_CALC_HPA:  state_next = ST_CALC_HPB;
      ST_CALC_HPB:  state_next = ST_MUL_BP;
      ST_MUL_BP:    state_next = ST_CALC_BP;
      ST_CALC_BP:   state_next = pass ? ST_SUM : ST_MUL_LP;
      ST_SUM:       state_next = ST_FIN;
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control flags, output valid and cell state store
  always_ff @(posedge clk) begin
    if (rst) begin
      pass      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < CELLS; i++) begin
        lp_mem[i]   <= '0;
        bp_mem[i]   <= '0;
        prev_mem[i] <= '0;
      end
    end else begin
      if (accept) begin
        pass <= 1'b0;
      end else if (state == ST_CALC_BP) begin
        pass <= 1'b1;
      end
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fin_load && live) begin
        lp_mem[idx_r]   <= lp;
        bp_mem[idx_r]   <= bp;
        prev_mem[idx_r] <= inp;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cell_r <= cell_req;
      live   <= live_in;
      ctl_r  <= control;
      inp    <= {{4{sample[15]}}, sample, 12'd0};
      lp     <= lp_mem[idx_in];
      bp     <= bp_mem[idx_in];
      prev   <= prev_mem[idx_in];
    end
    case (state)
      ST_CALC_CTRL: begin
        acc    <= {1'b0, 1'b1, mul_lo[26:0], 3'b000};
        shv    <= shv_raw[6] ? 5'd0 : shv_raw[4:0];
        hpbase <= {in_sum[31], in_sum[31:1]};
      end
      ST_CALC_SQ: begin
        acc <= mul_hi;
      end
      ST_CALC_POLY: begin
        acc <= $signed(poly_sum) >>> shv;
      end
      ST_CALC_FM: begin
        fm <= {fm_clamped[23:0], 8'd0};
      end
      ST_CALC_LP: begin
        lp <= lp + mulq;
      end
      ST_CALC_HPA: begin
        hp <= hpbase - lp;
      end
      ST_CALC_HPB: begin
        hp <= hp - mulq;
      end
      ST_CALC_BP: begin
        bp <= bp_sum;
        // first pass keeps its values for the averaged outputs and loads inp for the second
        if (!pass) begin
          lpt    <= lp;
          bpt    <= bp_sum;
          hpt    <= hp;
          hpbase <= inp;
        end
      end
      ST_SUM: begin
        olp <= sat16(lp + lpt);
        obp <= sat16(bp + bpt);
        ohp <= sat16(hp + hpt);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (fin_load) begin
      cell_out     <= cell_r;
      lowpass_out  <= live ? olp : 16'd0;
      bandpass_out <= live ? obp : 16'd0;
      highpass_out <= live ? ohp : 16'd0;
      if (!live) begin
        selected_out <= 16'd0;
      end else begin
        case (cfg.ftype)
          FT_LOWPASS:  selected_out <= olp;
          FT_BANDPASS: selected_out <= obp;
          default:     selected_out <= ohp;
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/fixed_point_state_variable_filter_top.sv
// a connected item runs through the sequencer states from ST_MUL_CTRL to ST_SUM and
//   then ST_FIN; a disconnected item (or a cell index past the cell count) goes to ST_FIN
// one item at a time: a new input is taken only in ST_IDLE, and the ten dependent
//   products all go through the one shared 32x32 multiplier
// reset: synchronous rst clears all cell state to zero and loads register defaults
module fixed_point_state_variable_filter_top import fpsvf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cell_req[2:0], sample[18:3], control[34:19], zero pad
  input  logic        s_tuser,   // connected
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // cell_out[2:0], selected_out[18:3], lowpass_out[34:19],
                                 // bandpass_out[50:35], highpass_out[66:51], zero pad
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_addr,
  input  logic [30:0] cfg_wdata
);

  cfg_t        cfg;
  mul_req_t    mul_req;
  logic [31:0] mul_hi, mul_lo;
  logic [2:0]  cell_out;
  logic [15:0] selected_out, lowpass_out, bandpass_out, highpass_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center  <= CENTER_RESET;
      cfg.damping <= DAMPING_RESET;
      cfg.depth   <= DEPTH_RESET;
      cfg.ftype   <= FT_LOWPASS;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_CENTER:  cfg.center  <= cfg_wdata;
        REG_DAMPING: cfg.damping <= cfg_wdata;
        REG_DEPTH:   cfg.depth   <= cfg_wdata[14:0];
        REG_FTYPE:   cfg.ftype   <= cfg_wdata[1:0];
        default:     cfg.ftype   <= cfg.ftype;
      endcase
    end
  end

  // shared multiplier
  fpsvf_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .hi  (mul_hi),
    .lo  (mul_lo)
  );

  // sequencer, datapath and cell state
  fpsvf_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .cell_req     (s_tdata[2:0]),
    .sample       (s_tdata[18:3]),
    .control      (s_tdata[34:19]),
    .connected    (s_tuser),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .cell_out     (cell_out),
    .selected_out (selected_out),
    .lowpass_out  (lowpass_out),
    .bandpass_out (bandpass_out),
    .highpass_out (highpass_out),
    .mul_req      (mul_req),
    .mul_hi       (mul_hi),
    .mul_lo       (mul_lo)
  );

  // result packing
  assign m_tdata = {5'd0, highpass_out, bandpass_out, lowpass_out, selected_out, cell_out};

`ifndef SYNTH
  // an input transfer makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  // selected output is always one of the three filter outputs
  a_sel_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[18:3] == m_tdata[34:19] || m_tdata[18:3] == m_tdata[50:35] ||
                  m_tdata[18:3] == m_tdata[66:51]))
    else $error("selected output differs from all filter outputs");

  // a new result means the sequencer is back to idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result shown while sequencer still busy");
`endif

endmodule

FILE: tb/sv/tb_fixed_point_state_variable_filter_top.sv
module tb_fixed_point_state_variable_filter_top import fpsvf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // highpass codes, two encodings select it
  localparam logic [1:0] FT_HIGHPASS     = 2'd2;
  localparam logic [1:0] FT_HIGHPASS_ALT = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0] cell_id;
    logic [15:0]       sel;
    logic [15:0]       lp;
    logic [15:0]       bp;
    logic [15:0]       hp;
  } filt_out_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // cell_req[2:0], sample[18:3], control[34:19], zero pad
  logic        s_tuser;   // connected
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // cell_out[2:0], selected_out[18:3], lowpass_out[34:19],
                          // bandpass_out[50:35], highpass_out[66:51], zero pad
  logic        cfg_wen;
  logic [1:0]  cfg_addr;
  logic [30:0] cfg_wdata;

  // shadow registers and per-cell filter state
  logic [30:0] coef_reg;
  logic [30:0] damp_reg;
  logic [14:0] depth_reg;
  logic [1:0]  ftype_reg;
  logic [31:0] lp_st   [CELLS];
  logic [31:0] bp_st   [CELLS];
  logic [31:0] prev_st [CELLS];

  filt_out_t pending_results[$];
  int        mismatch_count;
  bit        no_idle;

  fixed_point_state_variable_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // rounded upper half of a signed 32x32 product
  function automatic logic [31:0] mul_round_hi(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
    p = p + 64'h0000_0000_8000_0000;
    return p[63:32];
  endfunction

  function automatic logic [31:0] mul_q2(input logic [31:0] a, input logic [31:0] b);
    return mul_round_hi(a, b) << 2;
  endfunction

  // drop 13 fraction bits and clip to 16 bits
  function automatic logic [15:0] clip16(input logic [31:0] v);
    logic signed [31:0] s;
    s = $signed(v) >>> 13;
    if (s > 32767) return 16'h7FFF;
    if (s < -32768) return 16'h8000;
    return s[15:0];
  endfunction

  // expected result for one sample, advances the cell state
  function automatic filt_out_t predict_filter(input logic [CELL_W-1:0] cell_id,
                                               input logic [15:0] smp,
                                               input logic [15:0] ctl,
                                               input logic live);
    filt_out_t          r;
    logic signed [31:0] ctrl;
    logic signed [31:0] shv;
    logic [31:0]        n, fm, x, avg, dmp, lp, bp, hp, lpt, bpt, hpt;
    r = '0;
    r.cell_id = cell_id;
    if (!live || cell_id >= CELLS) return r;

    // exp2 approximation of the scaled control value
    ctrl = $signed(ctl) * $signed({17'd0, depth_reg});
    n = {5'd0, ctrl[26:0]};
    n = (n + 32'd134217728) << 3;
    n = mul_round_hi(n, n);
    n = mul_round_hi(n, POLY_GAIN) << 3;
    n = n + POLY_OFFSET;
    shv = 6 - (ctrl >>> 27);
    if (shv < 0) shv = 0;
    n = $signed(n) >>> shv;

    // cutoff multiplier with clamp
    fm = mul_round_hi({1'b0, coef_reg}, n);
    if ($signed(fm) > FM_LIMIT) fm = FM_LIMIT;
    fm = fm << 8;

    // two filter iterations, first one on the averaged input
    dmp = {1'b0, damp_reg};
    x = {{4{smp[15]}}, smp, 12'd0};
    lp = lp_st[cell_id];
    bp = bp_st[cell_id];
    lp = lp + mul_q2(fm, bp);
    avg = $signed(x + prev_st[cell_id]) >>> 1;
    hp = avg - lp - mul_q2(dmp, bp);
    bp = bp + mul_q2(fm, hp);
    lpt = lp;
    bpt = bp;
    hpt = hp;
    lp = lp + mul_q2(fm, bp);
    hp = x - lp - mul_q2(dmp, bp);
    bp = bp + mul_q2(fm, hp);

    lp_st[cell_id]   = lp;
    bp_st[cell_id]   = bp;
    prev_st[cell_id] = x;

    r.lp = clip16(lp + lpt);
    r.bp = clip16(bp + bpt);
    r.hp = clip16(hp + hpt);
    case (ftype_reg)
      FT_LOWPASS:  r.sel = r.lp;
      FT_BANDPASS: r.sel = r.bp;
      default:     r.sel = r.hp;
    endcase
    return r;
  endfunction

  // one sample transfer on the input side
  task automatic send_sample(input logic [CELL_W-1:0] cell_id, input logic [15:0] smp,
                             input logic [15:0] ctl, input logic live);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, ctl, smp, cell_id};
    s_tuser  <= live;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_filter(cell_id, smp, ctl, live));
  endtask

  // stop sending until every result is back and the block has settled
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_CENTER:  coef_reg  = val;
      REG_DAMPING: damp_reg  = val;
      REG_DEPTH:   depth_reg = val[14:0];
      REG_FTYPE:   ftype_reg = val[1:0];
      default:     ;
    endcase
  endtask

  task automatic apply_settings(input logic [30:0] coef, input logic [30:0] damp,
                                input logic [30:0] depth, input logic [1:0] ftype);
    hold_until_drained();
    write_reg(REG_CENTER, coef);
    write_reg(REG_DAMPING, damp);
    write_reg(REG_DEPTH, depth);
    write_reg(REG_FTYPE, {29'd0, ftype});
  endtask

  // mix of extremes, small values and full-range values
  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    case ($urandom_range(0, 5))
      0: w = 16'h7FFF;
      1: w = 16'h8000;
      2: begin
        w = 16'($urandom_range(0, 511));
        w = w - 16'd256;
      end
      default: w = 16'($urandom());
    endcase
    return w;
  endfunction

  task automatic send_random_sample();
    logic [CELL_W-1:0] cell_id;
    logic              live;
    cell_id = CELL_W'($urandom_range(0, CELLS - 1));
    live = ($urandom_range(0, 9) != 0);
    send_sample(cell_id, pick_word(), pick_word(), live);
  endtask

  // extremes of sample and control, disconnected cells keep their state
  task automatic test_directed_edges();
    send_sample(CELL_W'(0), 16'h7FFF, 16'h0000, 1'b1);
    send_sample(CELL_W'(0), 16'h7FFF, 16'h7FFF, 1'b1);
    send_sample(CELL_W'(0), 16'h8000, 16'h8000, 1'b1);
    send_sample(CELL_W'(0), 16'h04D2, 16'h03E7, 1'b0);
    send_sample(CELL_W'(0), 16'h0000, 16'h0000, 1'b1);
    send_sample(CELL_W'(7), 16'h8000, 16'h7FFF, 1'b1);
    send_sample(CELL_W'(7), 16'h7FFF, 16'h8000, 1'b1);
    for (int c = 1; c < 7; c++) begin
      send_sample(CELL_W'(c), c[0] ? 16'h5555 : 16'hAAAA, c[0] ? 16'hAAAA : 16'h5555, 1'b1);
    end
    send_sample(CELL_W'(3), 16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(CELL_W'(3), 16'hFFFF, 16'hFFFF, 1'b1);
  endtask

  // depth past its range so the exp2 shift clamps, type three picks highpass
  task automatic test_large_depth();
    apply_settings(CENTER_RESET, DAMPING_RESET, 31'h7FFF, FT_HIGHPASS_ALT);
    send_sample(CELL_W'(2), 16'h1000, 16'h7FFF, 1'b1);
    send_sample(CELL_W'(2), 16'hE000, 16'd29000, 1'b1);
    send_sample(CELL_W'(2), 16'h7FFF, 16'd28672, 1'b1);
    send_sample(CELL_W'(2), 16'h8000, 16'h8000, 1'b1);
    send_sample(CELL_W'(5), 16'h0123, 16'h7FFF, 1'b1);
  endtask

  // register extremes, each with a short burst of traffic
  task automatic test_register_sweep();
    apply_settings(31'd0, 31'd214748365, 31'd0, FT_BANDPASS);
    repeat (40) send_random_sample();
    apply_settings(31'd1349400000, 31'd1533916891, 31'd28671, FT_LOWPASS);
    repeat (40) send_random_sample();
    apply_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF, FT_HIGHPASS);
    repeat (40) send_random_sample();
    apply_settings(CENTER_RESET, 31'd0, 31'd4096, FT_HIGHPASS_ALT);
    repeat (40) send_random_sample();
    apply_settings(31'd1, 31'd1, 31'd1, FT_BANDPASS);
    repeat (40) send_random_sample();
  endtask

  // long random run over random settings, some phases without idle cycles
  task automatic test_random_traffic();
    logic [30:0] coef, damp, depth;
    logic [1:0]  ftype;
    for (int ph = 0; ph < 15; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        coef  = 31'($urandom());
        damp  = 31'($urandom());
        depth = 31'($urandom());
      end else begin
        coef  = 31'($urandom_range(0, 1349400000));
        damp  = 31'($urandom_range(214748365, 1533916891));
        depth = 31'($urandom_range(0, 28671));
      end
      ftype = 2'($urandom_range(0, 3));
      apply_settings(coef, damp, depth, ftype);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (110) send_random_sample();
    end
    no_idle = 1'b0;
  endtask

  // result side: random stalls, every transfer checked against the oldest expectation
  initial begin
    int        stall;
    bit        bad;
    filt_out_t got;
    filt_out_t want;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.cell_id = m_tdata[2:0];
      got.sel     = m_tdata[18:3];
      got.lp      = m_tdata[34:19];
      got.bp      = m_tdata[50:35];
      got.hp      = m_tdata[66:51];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] result with nothing expected: cell %0d sel %h lp %h bp %h hp %h",
                   $realtime, got.cell_id, got.sel, got.lp, got.bp, got.hp);
      end else begin
        want = pending_results.pop_front();
        bad = (got.cell_id !== want.cell_id) || (got.sel !== want.sel) ||
              (got.lp !== want.lp) || (got.bp !== want.bp) || (got.hp !== want.hp);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] mismatch exp: cell %0d sel %h lp %h bp %h hp %h",
                     $realtime, want.cell_id, want.sel, want.lp, want.bp, want.hp);
            $display("[%0t]          act: cell %0d sel %h lp %h bp %h hp %h",
                     $realtime, got.cell_id, got.sel, got.lp, got.bp, got.hp);
          end
        end
      end
    end
  end

  // reset, test sequence and final verdict
  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_addr  <= REG_CENTER;
    cfg_wdata <= '0;
    no_idle        = 1'b0;
    mismatch_count = 0;
    coef_reg  = CENTER_RESET;
    damp_reg  = DAMPING_RESET;
    depth_reg = DEPTH_RESET;
    ftype_reg = FT_LOWPASS;
    for (int c = 0; c < CELLS; c++) begin
      lp_st[c]   = '0;
      bp_st[c]   = '0;
      prev_st[c] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_large_depth();
    test_register_sweep();
    test_random_traffic();

    hold_until_drained();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/fpsvf_pkg.sv
hw/rtl/fpsvf_mul.sv
hw/rtl/fpsvf_core.sv
hw/rtl/fixed_point_state_variable_filter_top.sv
tb/sv/tb_fixed_point_state_variable_filter_top.sv
